/* rtl/core/wcg_pkg.sv */
// Shared types, constants and the cosine table builder for the window coefficient generator.
`default_nettype none

package wcg_pkg;

    localparam int IDX_W          = 13;
    localparam int CFG_W          = 13;
    localparam int KIND_W         = 3;
    localparam int CIDX_W         = 2;
    localparam int MAX_LEN_DEF    = 4096;
    localparam int COS_TABLE_BITS = 10;
    localparam int TURN_BITS      = COS_TABLE_BITS + 2;
    localparam int QUARTER        = 1 << COS_TABLE_BITS;
    localparam int ADDR_W         = COS_TABLE_BITS + 1;
    localparam int MAG_W          = 16;
    localparam int COEF_W         = 16;
    localparam int DIV_W          = 13;
    localparam int D_W            = DIV_W + 1;
    localparam int NUM_W          = (TURN_BITS + 17 > 30) ? TURN_BITS + 17 : 30;
    localparam int REC_W          = NUM_W + 1;
    localparam int QS_W           = (TURN_BITS > 17) ? TURN_BITS : 17;
    localparam int BART_SH        = 16;
    localparam int WGT_W          = 20;
    localparam int Q15_FRAC       = 15;
    localparam int PROD_W         = WGT_W + MAG_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int NLANE          = 3;
    localparam int NST            = 8;

    localparam logic [COEF_W-1:0] ONE_Q15 = 16'h8000;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [KIND_W-1:0] KIND_RECT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BART  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HANN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HAMM  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BLACK = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BH    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TUKEY = 3'd6;

    localparam logic [CIDX_W-1:0] REG_KIND = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SIZE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_OVER = 2'd2;

    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_BART  = 2'd1;
    localparam logic [1:0] MODE_COS   = 2'd2;

    localparam logic [1:0] WSEL_HANN  = 2'd0;
    localparam logic [1:0] WSEL_HAMM  = 2'd1;
    localparam logic [1:0] WSEL_BLACK = 2'd2;
    localparam logic [1:0] WSEL_BH    = 2'd3;

    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] wsel;
        logic       oor;
    } t_ctl;

    typedef logic [MAG_W-1:0] t_cos_tab [0:QUARTER];

    // term weights a0..a3 in Q0.20
    function automatic logic [WGT_W-1:0] wgt_of(input logic [1:0] wsel, input int k);
        logic [WGT_W-1:0] w;
        w = '0;
        case (wsel)
            WSEL_HANN: begin
                if (k == 0 || k == 1) w = 20'd524288;
            end
            WSEL_HAMM: begin
                if (k == 0) w = 20'd566231;
                else if (k == 1) w = 20'd482345;
            end
            WSEL_BLACK: begin
                if (k == 0) w = 20'd440402;
                else if (k == 1) w = 20'd524288;
                else if (k == 2) w = 20'd83886;
            end
            WSEL_BH: begin
                if (k == 0) w = 20'd376177;
                else if (k == 1) w = 20'd512009;
                else if (k == 2) w = 20'd148143;
                else w = 20'd12247;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // shift-subtract quotient of two non-negative values, elaboration time only
    function automatic longint div_floor(input longint a, input longint b);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int k = 62; k >= 0; k--) begin
            r = (r <<< 1) | ((a >>> k) & 64'sd1);
            q = q <<< 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // quarter-wave cosine, Q1.15, integer Taylor series evaluated at elaboration
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        longint   x;
        longint   term;
        longint   sum;
        for (int j = 0; j <= QUARTER; j++) begin
            x    = (HALF_PI_Q30 * longint'(j)) >>> COS_TABLE_BITS;
            term = 64'sd1 <<< 30;
            sum  = term;
            for (int n = 1; n <= 9; n++) begin
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                term = div_floor(term, longint'((2 * n - 1) * (2 * n)));
                if ((n & 1) == 1) sum = sum - term;
                else sum = sum + term;
            end
            if (sum < 0) sum = 0;
            tab[j] = MAG_W'((sum + (64'sd1 <<< 14)) >>> 15);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/wcg_recip.sv */
// Bit-serial reciprocal unit: floor(2^NUM_W / m) for the window and taper divisors.
`default_nettype none

module wcg_recip (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_start,
    input  wire logic [1:0][wcg_pkg::DIV_W-1:0]               i_div,
    output logic      [1:0][wcg_pkg::REC_W-1:0]               o_recip,
    output logic                                              o_busy
);
    import wcg_pkg::*;

    localparam int CNT_W = $clog2(REC_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0][DIV_W-1:0] r_rem;
    logic [1:0][REC_W-1:0] r_quo;
    logic [1:0][DIV_W-1:0] n_rem;
    logic [1:0]            n_ge;

    always_comb begin
        logic [DIV_W:0] sh;
        logic [DIV_W:0] dif;
        for (int l = 0; l < 2; l++) begin
            // dividend is a single one followed by zeros
            sh       = (r_cnt == '0) ? {{DIV_W{1'b0}}, 1'b1} : {r_rem[l], 1'b0};
            dif      = sh - {1'b0, i_div[l]};
            n_ge[l]  = sh >= {1'b0, i_div[l]};
            n_rem[l] = n_ge[l] ? dif[DIV_W-1:0] : sh[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(REC_W - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= n_rem[l];
                r_quo[l] <= {r_quo[l][REC_W-2:0], n_ge[l]};
            end
        end
    end

    assign o_recip = r_quo;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

/* rtl/core/wcg_front.sv */
// Front stages: range check and kind decode, then dividend, divisor and reciprocal select.
`default_nettype none

module wcg_front #(
    parameter int MAX_LEN = wcg_pkg::MAX_LEN_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic [1:0]                                   i_en,
    input  wire logic [wcg_pkg::IDX_W-1:0]                    i_index,
    input  wire logic [wcg_pkg::KIND_W-1:0]                   i_kind,
    input  wire logic [wcg_pkg::CFG_W-1:0]                    i_size,
    input  wire logic [wcg_pkg::CFG_W-1:0]                    i_over,
    input  wire logic [1:0][wcg_pkg::REC_W-1:0]               i_recip,
    output logic      [wcg_pkg::NLANE-1:0][wcg_pkg::NUM_W-1:0] o_num,
    output logic      [wcg_pkg::D_W-1:0]                      o_den,
    output logic      [wcg_pkg::REC_W-1:0]                    o_rcp,
    output wcg_pkg::t_ctl                                     o_ctl
);
    import wcg_pkg::*;

    localparam int LEN_W = ($clog2(MAX_LEN + 1) > CFG_W + 1) ? $clog2(MAX_LEN + 1) : CFG_W + 1;

    // stage 1
    logic [IDX_W-1:0] r1_idx;
    t_ctl             r1_ctl;
    logic             r1_hi;
    logic             r1_tukey;
    t_ctl             n1_ctl;
    logic [LEN_W-1:0] n1_len;

    always_comb begin
        logic [CFG_W:0]   len_raw;
        logic [LEN_W-1:0] len_ext;
        logic             lo;
        logic             hi;
        len_raw = (i_kind == KIND_TUKEY) ? {1'b0, i_size} + {1'b0, i_over} : {1'b0, i_size};
        len_ext = LEN_W'(len_raw);
        n1_len  = (len_ext > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_ext;
        hi      = i_index >= i_size;
        lo      = i_index < i_over;
        n1_ctl.mode = MODE_FIXED;
        n1_ctl.wsel = WSEL_HANN;
        n1_ctl.oor  = LEN_W'(i_index) >= n1_len;
        case (i_kind)
            KIND_BART: begin
                if (i_size != CFG_W'(1)) n1_ctl.mode = MODE_BART;
            end
            KIND_HANN, KIND_HAMM, KIND_BLACK, KIND_BH: begin
                if (i_size != CFG_W'(1)) n1_ctl.mode = MODE_COS;
                n1_ctl.wsel = 2'(i_kind - KIND_HANN);
            end
            KIND_TUKEY: begin
                // taper is hann-shaped; an overlap of one gives full scale
                if ((hi || lo) && i_over != CFG_W'(1)) n1_ctl.mode = MODE_COS;
            end
            default: n1_ctl.mode = MODE_FIXED;
        endcase
        if (n1_ctl.oor) n1_ctl.mode = MODE_FIXED;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_idx   <= i_index;
            r1_ctl   <= n1_ctl;
            r1_hi    <= i_index >= i_size;
            r1_tukey <= i_kind == KIND_TUKEY;
        end
    end

    // stage 2
    logic [NLANE-1:0][NUM_W-1:0] r2_num;
    logic [D_W-1:0]              r2_den;
    logic [REC_W-1:0]            r2_rcp;
    t_ctl                        r2_ctl;
    logic [NLANE-1:0][NUM_W-1:0] n2_num;
    logic [D_W-1:0]              n2_den;
    logic [REC_W-1:0]            n2_rcp;

    always_comb begin
        logic [DIV_W-1:0] m_w;
        logic [DIV_W-1:0] m_t;
        logic [DIV_W:0]   i2;
        logic [DIV_W:0]   d;
        logic [DIV_W:0]   j;
        logic [NUM_W-1:0] iw;
        m_w = i_size - DIV_W'(1);
        m_t = i_over - DIV_W'(1);
        i2  = {r1_idx, 1'b0};
        d   = (i2 >= {1'b0, m_w}) ? i2 - {1'b0, m_w} : {1'b0, m_w} - i2;
        j   = r1_hi ? {1'b0, i_size} + {1'b0, i_over} - (DIV_W + 1)'(1) - {1'b0, r1_idx}
                    : {1'b0, r1_idx};
        iw  = NUM_W'(r1_idx);
        n2_num = '0;
        if (r1_tukey) begin
            n2_num[0] = (NUM_W'(j) << TURN_BITS) + NUM_W'(m_t);
            n2_den    = {m_t, 1'b0};
            n2_rcp    = i_recip[1];
        end else begin
            n2_den = {m_w, 1'b0};
            n2_rcp = i_recip[0];
            if (r1_ctl.mode == MODE_BART) begin
                n2_num[0] = (NUM_W'(d) << BART_SH) + NUM_W'(m_w);
            end else begin
                // 2*k*i turns plus m, for rounding to nearest step
                n2_num[0] = (iw << (TURN_BITS + 1)) + NUM_W'(m_w);
                n2_num[1] = (iw << (TURN_BITS + 2)) + NUM_W'(m_w);
                n2_num[2] = ((iw + (iw << 1)) << (TURN_BITS + 1)) + NUM_W'(m_w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_num <= n2_num;
            r2_den <= n2_den;
            r2_rcp <= n2_rcp;
            r2_ctl <= r1_ctl;
        end
    end

    assign o_num = r2_num;
    assign o_den = r2_den;
    assign o_rcp = r2_rcp;
    assign o_ctl = r2_ctl;

endmodule

`default_nettype wire

/* rtl/core/wcg_lane.sv */
// One harmonic lane: quotient by reciprocal multiply with correction, then cosine lookup.
`default_nettype none

module wcg_lane (
    input  wire logic                        i_clk,
    input  wire logic [3:0]                  i_en,
    input  wire logic [wcg_pkg::NUM_W-1:0]   i_num,
    input  wire logic [wcg_pkg::D_W-1:0]     i_den,
    input  wire logic [wcg_pkg::REC_W-1:0]   i_rcp,
    output logic      [wcg_pkg::QS_W-1:0]    o_q,
    output logic      [wcg_pkg::MAG_W-1:0]   o_mag,
    output logic                             o_neg
);
    import wcg_pkg::*;

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // stage 3: estimate, low by at most one
    logic [NUM_W-1:0]       r3_est;
    logic [NUM_W-1:0]       r3_num;
    logic [D_W-1:0]         r3_den;
    logic [NUM_W+REC_W-1:0] n3_prod;

    assign n3_prod = (NUM_W + REC_W)'(i_num) * (NUM_W + REC_W)'(i_rcp);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r3_est <= n3_prod[NUM_W+REC_W-1:REC_W];
            r3_num <= i_num;
            r3_den <= i_den;
        end
    end

    // stage 4: est * den
    logic [REC_W-1:0]     r4_ed;
    logic [NUM_W-1:0]     r4_est;
    logic [NUM_W-1:0]     r4_num;
    logic [D_W-1:0]       r4_den;
    logic [NUM_W+D_W-1:0] n4_ed;

    assign n4_ed = (NUM_W + D_W)'(r3_est) * (NUM_W + D_W)'(r3_den);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r4_ed  <= n4_ed[REC_W-1:0];
            r4_est <= r3_est;
            r4_num <= r3_num;
            r4_den <= r3_den;
        end
    end

    // stage 5: remainder check and correction
    logic [QS_W-1:0]  r5_q;
    logic [REC_W-1:0] n5_rem;
    logic [NUM_W-1:0] n5_q;

    assign n5_rem = REC_W'(r4_num) - r4_ed;
    assign n5_q   = r4_est + NUM_W'(n5_rem >= REC_W'(r4_den));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) r5_q <= n5_q[QS_W-1:0];
    end

    // stage 6: quadrant fold and table read
    logic [QS_W-1:0]   r6_q;
    logic [MAG_W-1:0]  r6_mag;
    logic              r6_neg;
    logic [1:0]        n6_quad;
    logic [ADDR_W-1:0] n6_addr;

    always_comb begin
        logic [ADDR_W-1:0] r;
        n6_quad = r5_q[TURN_BITS-1 -: 2];
        r       = ADDR_W'(r5_q[COS_TABLE_BITS-1:0]);
        n6_addr = n6_quad[0] ? ADDR_W'(QUARTER) - r : r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r6_mag <= COS_TAB[n6_addr];
            r6_neg <= (n6_quad == QUAD_1) || (n6_quad == QUAD_2);
            r6_q   <= r5_q;
        end
    end

    assign o_q   = r6_q;
    assign o_mag = r6_mag;
    assign o_neg = r6_neg;

endmodule

`default_nettype wire

/* rtl/core/wcg_back.sv */
// Back stages: weighted cosine products, then sum, round, clamp and result select.
`default_nettype none

module wcg_back (
    input  wire logic                                          i_clk,
    input  wire logic [1:0]                                    i_en,
    input  wire wcg_pkg::t_ctl                                 i_ctl,
    input  wire logic [wcg_pkg::QS_W-1:0]                      i_q1,
    input  wire logic [wcg_pkg::NLANE-1:0][wcg_pkg::MAG_W-1:0] i_mag,
    input  wire logic [wcg_pkg::NLANE-1:0]                     i_neg,
    output logic      [wcg_pkg::COEF_W-1:0]                    o_coef,
    output logic                                               o_oor
);
    import wcg_pkg::*;

    localparam int RND_SH = WGT_W;
    localparam int V_W    = SUM_W - RND_SH;

    // stage 7
    logic [NLANE-1:0][PROD_W-1:0] r7_p;
    logic [NLANE-1:0]             r7_sub;
    logic [WGT_W-1:0]             r7_a0;
    t_ctl                         r7_ctl;
    logic [QS_W-1:0]              r7_q1;
    logic [NLANE-1:0][PROD_W-1:0] n7_p;
    logic [NLANE-1:0]             n7_sub;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            n7_p[l]   = PROD_W'(wgt_of(i_ctl.wsel, l + 1)) * PROD_W'(i_mag[l]);
            // odd harmonics enter with a minus sign
            n7_sub[l] = i_neg[l] ^ ((l % 2) == 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r7_p   <= n7_p;
            r7_sub <= n7_sub;
            r7_a0  <= wgt_of(i_ctl.wsel, 0);
            r7_ctl <= i_ctl;
            r7_q1  <= i_q1;
        end
    end

    // stage 8
    logic [COEF_W-1:0] r8_coef;
    logic              r8_oor;
    logic [COEF_W-1:0] n8_coef;

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] rnd;
        logic [V_W-1:0]          v;
        logic [COEF_W-1:0]       cosv;
        logic [COEF_W-1:0]       bart;
        sum = $signed(SUM_W'({r7_a0, {Q15_FRAC{1'b0}}}));
        for (int l = 0; l < NLANE; l++) begin
            if (r7_sub[l]) sum = sum - $signed(SUM_W'(r7_p[l]));
            else sum = sum + $signed(SUM_W'(r7_p[l]));
        end
        rnd = sum + $signed(SUM_W'(1) << (RND_SH - 1));
        v   = rnd[SUM_W-1:RND_SH];
        if (sum <= 0) cosv = '0;
        else if (v > V_W'(ONE_Q15)) cosv = ONE_Q15;
        else cosv = v[COEF_W-1:0];
        if (r7_q1 >= QS_W'(ONE_Q15)) bart = '0;
        else bart = COEF_W'(QS_W'(ONE_Q15) - r7_q1);
        case (r7_ctl.mode)
            MODE_BART: n8_coef = bart;
            MODE_COS:  n8_coef = cosv;
            default:   n8_coef = r7_ctl.oor ? '0 : ONE_Q15;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r8_coef <= n8_coef;
            r8_oor  <= r7_ctl.oor;
        end
    end

    assign o_coef = r8_coef;
    assign o_oor  = r8_oor;

endmodule

`default_nettype wire

/* rtl/core/window_coefficient_generator_unit.sv */
// An accepted index word runs through the front, lane and back stages to its coefficient word on the output.
// Throughput: one word per cycle when not stalled; each stage holds its word only while the stage
// behind it is full. Reset: kind 0, size 1024, overlap 0; the bit-serial reciprocal unit then
// works out the quotient bits (one quotient bit a cycle) and s_axis_tready stays low meanwhile;
// the same run follows every configuration write.
`default_nettype none

module window_coefficient_generator_unit #(
    parameter int MAX_LEN = wcg_pkg::MAX_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,   // [12:0] sample_index
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // [15:0] coefficient
    output logic [0:0]                         m_axis_tuser,   // [0] out_of_range
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [wcg_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [wcg_pkg::CFG_W-1:0]     i_cfg_data
);
    import wcg_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [CFG_W-1:0]  r_size;
    logic [CFG_W-1:0]  r_over;
    logic              cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RECT;
            r_size <= CFG_W'(1024);
            r_over <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_KIND: r_kind <= i_cfg_data[KIND_W-1:0];
                REG_SIZE: r_size <= i_cfg_data;
                REG_OVER: r_over <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // reciprocals of size-1 and overlap-1
    logic [1:0][DIV_W-1:0] div;
    logic [1:0][REC_W-1:0] recip;
    logic                  busy;

    assign div[0] = r_size - DIV_W'(1);
    assign div[1] = r_over - DIV_W'(1);

    wcg_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_div   (div),
        .o_recip (recip),
        .o_busy  (busy)
    );

    // stage valids and enables
    logic [NST-1:0] r_v;
    logic [NST-1:0] pipe_en;
    logic           in_acc;

    always_comb begin
        pipe_en[NST-1] = !r_v[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) pipe_en[k] = !r_v[k] || pipe_en[k+1];
    end

    assign s_axis_tready = pipe_en[0] && !busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (pipe_en[0]) r_v[0] <= in_acc;
            for (int k = 1; k < NST; k++) begin
                if (pipe_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    logic [NLANE-1:0][NUM_W-1:0] num;
    logic [D_W-1:0]              den;
    logic [REC_W-1:0]            rcp;
    t_ctl                        ctl2;

    wcg_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk   (i_clk),
        .i_en    (pipe_en[1:0]),
        .i_index (s_axis_tdata[IDX_W-1:0]),
        .i_kind  (r_kind),
        .i_size  (r_size),
        .i_over  (r_over),
        .i_recip (recip),
        .o_num   (num),
        .o_den   (den),
        .o_rcp   (rcp),
        .o_ctl   (ctl2)
    );

    // control word follows the lanes
    t_ctl r_ctl3;
    t_ctl r_ctl4;
    t_ctl r_ctl5;
    t_ctl r_ctl6;

    always_ff @(posedge i_clk) begin
        if (pipe_en[2]) r_ctl3 <= ctl2;
        if (pipe_en[3]) r_ctl4 <= r_ctl3;
        if (pipe_en[4]) r_ctl5 <= r_ctl4;
        if (pipe_en[5]) r_ctl6 <= r_ctl5;
    end

    logic [NLANE-1:0][QS_W-1:0]  q;
    logic [NLANE-1:0][MAG_W-1:0] mag;
    logic [NLANE-1:0]            neg;

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        wcg_lane u_lane (
            .i_clk (i_clk),
            .i_en  (pipe_en[5:2]),
            .i_num (num[l]),
            .i_den (den),
            .i_rcp (rcp),
            .o_q   (q[l]),
            .o_mag (mag[l]),
            .o_neg (neg[l])
        );
    end

    logic [COEF_W-1:0] coef;
    logic              oor;

    wcg_back u_back (
        .i_clk  (i_clk),
        .i_en   (pipe_en[7:6]),
        .i_ctl  (r_ctl6),
        .i_q1   (q[0]),
        .i_mag  (mag),
        .i_neg  (neg),
        .o_coef (coef),
        .o_oor  (oor)
    );

    assign m_axis_tvalid   = r_v[NST-1];
    assign m_axis_tdata    = coef;
    assign m_axis_tuser[0] = oor;

`ifndef SYNTH
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("index word taken while reciprocal unit busy");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> busy)
        else $error("config write did not restart reciprocal unit");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("out-of-range word with nonzero coefficient");

    a_coef_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= ONE_Q15)
        else $error("coefficient above one");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the window coefficient generator: directed table, then random indexes.
`default_nettype none

module tb;
    import wcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXLEN    = 4096;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] coef;
        logic        oor;
    } t_coef_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    window_coefficient_generator_unit u_top (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [2:0]  win_kind = 3'd0;
    logic [12:0] win_size = 13'd1024;
    logic [12:0] ovl_size = 13'd0;
    int          cos_q[0:QUARTER];
    t_coef_word  coef_q[$];
    int          n_fail = 0;
    bit          rx_idle_on = 1'b1;
    bit          stall_hold = 1'b0;
    int          cycles = 0;

    function automatic int cos_at(int idx);
        int q, r;
        q = (idx >> COS_TABLE_BITS) & 3;
        r = idx & (QUARTER - 1);
        case (q)
            0: return cos_q[r];
            1: return -cos_q[QUARTER - r];
            2: return -cos_q[r];
            default: return cos_q[QUARTER - r];
        endcase
    endfunction

    function automatic longint round_q15(longint s);
        longint v;
        if (s <= 0) return 0;
        v = (s + (64'sd1 << 19)) >>> 20;
        return (v > 32768) ? 32768 : v;
    endfunction

    function automatic longint cos_sum(longint a0, longint a1, longint a2, longint a3,
                                       longint i, longint m);
        longint s, num, w;
        int idx;
        s = a0 * 32768;
        for (int k = 1; k <= 3; k++) begin
            w = (k == 1) ? a1 : (k == 2) ? a2 : a3;
            num = (longint'(k) * i) << TURN_BITS;
            idx = int'(((2 * num + m) / (2 * m)) & ((1 << TURN_BITS) - 1));
            if (k & 1) s = s - w * cos_at(idx);
            else s = s + w * cos_at(idx);
        end
        return round_q15(s);
    endfunction

    function automatic longint taper_of(longint j, longint k);
        int idx;
        if (k == 0) return 32768;
        idx = int'((((j << TURN_BITS) + k) / (2 * k)) & ((1 << TURN_BITS) - 1));
        return round_q15(64'sd524288 * 32768 - 64'sd524288 * cos_at(idx));
    endfunction

    function automatic t_coef_word window_value(logic [12:0] idx);
        t_coef_word w;
        longint len, i, m, d, f, c;
        i = idx;
        len = (win_kind == KIND_TUKEY) ? longint'(win_size) + ovl_size : win_size;
        if (len > MAXLEN) len = MAXLEN;
        w.oor = 1'b0;
        if (i >= len) begin
            w.coef = '0;
            w.oor = 1'b1;
            return w;
        end
        c = 32768;
        m = longint'(win_size) - 1;
        case (win_kind)
            KIND_BART: if (m != 0) begin
                d = (2 * i > m) ? 2 * i - m : m - 2 * i;
                f = (d * 65536 + m) / (2 * m);
                c = (f >= 32768) ? 0 : 32768 - f;
            end
            KIND_HANN:  if (m != 0) c = cos_sum(524288, 524288, 0, 0, i, m);
            KIND_HAMM:  if (m != 0) c = cos_sum(566231, 482345, 0, 0, i, m);
            KIND_BLACK: if (m != 0) c = cos_sum(440402, 524288, 83886, 0, i, m);
            KIND_BH:    if (m != 0) c = cos_sum(376177, 512009, 148143, 12247, i, m);
            KIND_TUKEY: begin
                if (i >= win_size)
                    c = taper_of(longint'(win_size) + ovl_size - 1 - i, longint'(ovl_size) - 1);
                else if (i < ovl_size)
                    c = taper_of(i, longint'(ovl_size) - 1);
            end
            default: ;
        endcase
        w.coef = c[15:0];
        return w;
    endfunction

    // sender: valid stays up between back-to-back words
    task automatic send_index(logic [12:0] idx, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx};
        coef_q.push_back(window_value(idx));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] ri, logic [12:0] val);
        s_axis_tvalid <= 1'b0;
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (ri)
            REG_KIND: win_kind = val[2:0];
            REG_SIZE: win_size = val;
            default:  ovl_size = val;
        endcase
    endtask

    task automatic set_window(logic [2:0] k, logic [12:0] n, logic [12:0] ov);
        write_reg(REG_KIND, {10'd0, k});
        write_reg(REG_SIZE, n);
        write_reg(REG_OVER, ov);
    endtask

    // receiver: random stalls, plus an optional long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_hold) begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < 200; c++) @(posedge i_clk);
                stall_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_coef_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (coef_q.size() == 0) begin
                $display("%0t: unexpected word coef=%0d oor=%0b", $time,
                         m_axis_tdata, m_axis_tuser[0]);
                n_fail++;
            end else begin
                exp_w = coef_q.pop_front();
                if (m_axis_tdata !== exp_w.coef) begin
                    $display("%0t: coefficient expected %0d actual %0d", $time,
                             exp_w.coef, m_axis_tdata);
                    n_fail++;
                end
                if (m_axis_tuser[0] !== exp_w.oor) begin
                    $display("%0t: out_of_range expected %0b actual %0b", $time,
                             exp_w.oor, m_axis_tuser[0]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // directed rows: kind, size, overlap, index, typed result (chk=1) or predictor (chk=0)
    typedef struct {
        logic [2:0]  kind;
        logic [12:0] size;
        logic [12:0] ovl;
        logic [12:0] idx;
        bit          chk;
        logic [15:0] coef;
        logic        oor;
    } t_row;

    t_row rows[$];

    initial begin
        t_coef_word w;
        logic [2:0] k;
        logic [12:0] n, ov;
        int mode;
        for (int j = 0; j <= QUARTER; j++) begin
            longint x, term, s;
            x = (HALF_PI_Q30 * j) >>> COS_TABLE_BITS;
            term = 64'sd1 << 30;
            s = term;
            for (int t = 1; t <= 9; t++) begin
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                term = term / ((2 * t - 1) * (2 * t));
                s = (t & 1) ? s - term : s + term;
            end
            if (s < 0) s = 0;
            cos_q[j] = int'((s + (64'sd1 << 14)) >>> 15);
        end

        rows = '{
            '{KIND_RECT,  13'd1024, 13'd0, 13'd0,    1'b1, 16'd32768, 1'b0},
            '{KIND_RECT,  13'd1024, 13'd0, 13'd1023, 1'b1, 16'd32768, 1'b0},
            '{KIND_RECT,  13'd1024, 13'd0, 13'd1024, 1'b1, 16'd0,     1'b1},
            '{KIND_RECT,  13'd1024, 13'd0, 13'd8191, 1'b1, 16'd0,     1'b1},
            '{KIND_RECT,  13'd0,    13'd0, 13'd0,    1'b1, 16'd0,     1'b1},
            '{KIND_BART,  13'd1,    13'd0, 13'd0,    1'b1, 16'd32768, 1'b0},
            '{KIND_BART,  13'd9,    13'd0, 13'd0,    1'b1, 16'd0,     1'b0},
            '{KIND_BART,  13'd9,    13'd0, 13'd4,    1'b1, 16'd32768, 1'b0},
            '{KIND_HANN,  13'd1,    13'd0, 13'd0,    1'b1, 16'd32768, 1'b0},
            '{KIND_HANN,  13'd9,    13'd0, 13'd0,    1'b1, 16'd0,     1'b0},
            '{KIND_HANN,  13'd9,    13'd0, 13'd4,    1'b1, 16'd32768, 1'b0},
            '{KIND_HAMM,  13'd64,   13'd0, 13'd5,    1'b0, 16'd0,     1'b0},
            '{KIND_BLACK, 13'd4096, 13'd0, 13'd0,    1'b0, 16'd0,     1'b0},
            '{KIND_BLACK, 13'd4096, 13'd0, 13'd4095, 1'b0, 16'd0,     1'b0},
            '{KIND_BH,    13'd8191, 13'd0, 13'd4095, 1'b0, 16'd0,     1'b0},
            '{KIND_BH,    13'd8191, 13'd0, 13'd4096, 1'b1, 16'd0,     1'b1},
            '{KIND_TUKEY, 13'd10,   13'd1, 13'd0,    1'b1, 16'd32768, 1'b0},
            '{KIND_TUKEY, 13'd10,   13'd1, 13'd10,   1'b1, 16'd32768, 1'b0},
            '{KIND_TUKEY, 13'd10,   13'd6, 13'd3,    1'b0, 16'd0,     1'b0},
            '{KIND_TUKEY, 13'd10,   13'd6, 13'd12,   1'b0, 16'd0,     1'b0},
            '{KIND_TUKEY, 13'd4,    13'd8, 13'd2,    1'b0, 16'd0,     1'b0},
            '{KIND_TUKEY, 13'd4,    13'd8, 13'd11,   1'b0, 16'd0,     1'b0},
            '{KIND_TUKEY, 13'd0,    13'd0, 13'd0,    1'b1, 16'd0,     1'b1},
            '{3'd7,       13'd20,   13'd0, 13'd19,   1'b1, 16'd32768, 1'b0},
            '{3'd7,       13'd20,   13'd0, 13'd20,   1'b1, 16'd0,     1'b1}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            // first rows run on the reset settings
            if (r != 0 && (rows[r].kind != win_kind || rows[r].size != win_size
                           || rows[r].ovl != ovl_size))
                set_window(rows[r].kind, rows[r].size, rows[r].ovl);
            w = window_value(rows[r].idx);
            if (rows[r].chk && (w.coef !== rows[r].coef || w.oor !== rows[r].oor)) begin
                $display("%0t: table row %0d expected %0d/%0b actual %0d/%0b", $time, r,
                         rows[r].coef, rows[r].oor, w.coef, w.oor);
                n_fail++;
            end
            send_index(rows[r].idx, 1'b0);
        end

        // random phases of 50 words each
        for (int ph = 0; ph < 15; ph++) begin
            k = 3'($urandom_range(0, 7));
            mode = $urandom_range(0, 9);
            n = (mode == 0) ? 13'd4096 : (mode == 1) ? 13'($urandom_range(0, 8191))
                : (mode == 2) ? 13'd1 : 13'($urandom_range(1, 200));
            ov = (mode == 3) ? 13'd4096 : 13'($urandom_range(0, 200));
            set_window(k, n, ov);
            if (ph == 3) stall_hold = 1'b1;
            if (ph == 13) rx_idle_on = 1'b0;
            for (int t = 0; t < 50; t++) begin
                if ($urandom_range(0, 9) == 0)
                    send_index(13'($urandom()), ph < 13);
                else
                    send_index(13'($urandom_range(0, int'(n) + int'(ov) + 2)), ph < 13);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
